@@ rtl/core/min_heap_value_replace_macros.svh @@
// Assertion helpers shared by the heap block. The enclosing module must have
// signals named clock and reset.
`ifndef MIN_HEAP_VALUE_REPLACE_MACROS_SVH
`define MIN_HEAP_VALUE_REPLACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHVR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHVR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mhvr_pkg.sv @@
package mhvr_pkg;

   localparam int HEAP_DEPTH_DEF = 256;
   localparam int DATA_W         = 32;
   localparam int SLOT_W         = 8;
   localparam int COUNT_W        = 9;
   localparam int REQ_DATA_W     = 72;
   localparam int RSP_DATA_W     = 64;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_APPEND  = 2'd1,
      KIND_REPLACE = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_RANGE     = 2'd3
   } status_type;

endpackage

@@ rtl/core/mhvr_ram.sv @@
module mhvr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/min_heap_value_replace.sv @@
// Channel  Direction  Ports                 Contents
// req      in         req_tvalid/tready     kind in tuser; old, new value, read index in tdata
// rsp      out        rsp_tvalid/tready     status in tuser; slots, read value, count in tdata
//
// Clear, append and a rejected item go straight to the response and a read fetches one slot;
// a replace scans the slots in order for the old value, and on a match the new value moves up
// past larger parents, then down past smaller children, before its write-back (one read port).
// Synchronous reset empties the heap; stored values are not cleared.
// A finished result waits in the output register while the next beat is accepted;
// a stalled rsp side holds the block only when a second result is ready.
module min_heap_value_replace
   import mhvr_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] old_value, [63:32] new_value, [71:64] read_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] found_slot, [15:8] final_slot, [47:16] read_value, [56:48] entry_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   `include "min_heap_value_replace_macros.svh"

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int NW    = CMP_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_SCAN, S_UP, S_UP_CMP, S_DOWN, S_LEFT, S_RIGHT, S_FINISH, S_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         found_ff, found_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] lval_ff, lval_in;
   logic signed [DATA_W-1:0] rval_ff, rval_in;
   status_type               stat_ff, stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr, ram_raddr;
   logic [DATA_W-1:0]        ram_wdata, ram_rdata;
   logic                     rd_req;
   logic signed [DATA_W-1:0] rdv;

   logic signed [DATA_W-1:0] in_old, in_new;
   logic [CMP_W-1:0]         ridx_c, cnt_c, pos_c, found_c, pos_next_c;
   logic [NW-1:0]            lc_n, rc_n, cnt_n;
   logic [IDX_W-1:0]         parent, pos_next, lc_idx, rc_idx;
   logic                     full, scan_last, pick_right, out_free;
   logic signed [DATA_W-1:0] pick_val;

   mhvr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rdv        = signed'(ram_rdata);
   assign in_old     = signed'(req_tdata[31:0]);
   assign in_new     = signed'(req_tdata[63:32]);
   assign ridx_c     = CMP_W'(req_tdata[71:64]);
   assign cnt_c      = CMP_W'(cnt_ff);
   assign pos_c      = CMP_W'(pos_ff);
   assign found_c    = CMP_W'(found_ff);
   assign full       = (cnt_c == CMP_W'(HEAP_DEPTH));
   assign parent     = (pos_ff - IDX_W'(1)) >> 1;
   assign pos_next   = pos_ff + IDX_W'(1);
   assign pos_next_c = pos_c + CMP_W'(1);
   assign scan_last  = (pos_next_c == cnt_c);
   assign lc_n       = {pos_c, 1'b1};
   assign rc_n       = lc_n + NW'(1);
   assign cnt_n      = NW'(cnt_ff);
   assign lc_idx     = lc_n[IDX_W-1:0];
   assign rc_idx     = rc_n[IDX_W-1:0];
   // On a tie between the children the left one wins.
   assign pick_right = (rdv < lval_ff);
   assign pick_val   = pick_right ? rdv : lval_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      cur_in       = cur_ff;
      key_in       = key_ff;
      lval_in      = lval_ff;
      rval_in      = rval_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;
      rd_req       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pos_in   = '0;
               found_in = '0;
               rval_in  = '0;
               stat_in  = STAT_OK;
               key_in   = in_old;
               cur_in   = in_new;
               state_in = S_EMIT;
               unique case (kind_type'(req_tuser))
                  KIND_CLEAR: begin
                     cnt_in = '0;
                  end
                  KIND_APPEND: begin
                     if (full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_c[IDX_W-1:0];
                        ram_wdata = in_old;
                        cnt_in    = cnt_ff + CNT_W'(1);
                     end
                  end
                  KIND_REPLACE: begin
                     if (cnt_c == '0) begin
                        stat_in = STAT_NOT_FOUND;
                     end else begin
                        rd_req   = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  KIND_READ: begin
                     if (ridx_c >= cnt_c) begin
                        stat_in = STAT_RANGE;
                     end else begin
                        rd_req    = 1'b1;
                        ram_raddr = ridx_c[IDX_W-1:0];
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     stat_in = STAT_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            rval_in  = rdv;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            // The slot in pos_ff was read in the previous cycle.
            if (rdv == key_ff) begin
               found_in = pos_ff;
               state_in = S_UP;
            end else if (scan_last) begin
               stat_in  = STAT_NOT_FOUND;
               pos_in   = '0;
               state_in = S_EMIT;
            end else begin
               rd_req    = 1'b1;
               ram_raddr = pos_next;
               pos_in    = pos_next;
            end
         end
         S_UP: begin
            if (pos_ff == '0) begin
               state_in = S_DOWN;
            end else begin
               rd_req    = 1'b1;
               ram_raddr = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // The moving value stays in cur_ff and is written once it settles.
            if (cur_ff < rdv) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = rdv;
               pos_in    = parent;
               state_in  = S_UP;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            if (lc_n >= cnt_n) begin
               state_in = S_FINISH;
            end else begin
               rd_req    = 1'b1;
               ram_raddr = lc_idx;
               state_in  = S_LEFT;
            end
         end
         S_LEFT: begin
            lval_in = rdv;
            if (rc_n < cnt_n) begin
               rd_req    = 1'b1;
               ram_raddr = rc_idx;
               state_in  = S_RIGHT;
            end else if (cur_ff > rdv) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = rdv;
               pos_in    = lc_idx;
               state_in  = S_UP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RIGHT: begin
            if (cur_ff > pick_val) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = pick_val;
               pos_in    = pick_right ? rc_idx : lc_idx;
               state_in  = S_UP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = cur_ff;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = stat_ff;
               rsp_data_in  = {7'b0, cnt_c[COUNT_W-1:0], rval_ff,
                               pos_c[SLOT_W-1:0], found_c[SLOT_W-1:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      cur_ff      <= cur_in;
      key_ff      <= key_in;
      lval_ff     <= lval_in;
      rval_ff     <= rval_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `MHVR_ASSERT_NOW(a_count_bound, 1'b1, cnt_c <= CMP_W'(HEAP_DEPTH),
      "entry count exceeds heap depth")
   `MHVR_ASSERT_NOW(a_no_rw_overlap, ram_we && rd_req, ram_waddr != ram_raddr,
      "heap store read and written at the same slot in one cycle")
   `MHVR_ASSERT_NOW(a_pos_in_heap,
      (state_ff == S_SCAN) || (state_ff == S_UP) || (state_ff == S_UP_CMP) ||
      (state_ff == S_DOWN) || (state_ff == S_LEFT) || (state_ff == S_RIGHT) ||
      (state_ff == S_FINISH),
      pos_c < cnt_c, "working slot lies outside the filled part of the heap")
   `MHVR_ASSERT_NEXT(a_emit_loads, (state_ff == S_EMIT) && out_free, rsp_valid_ff,
      "result not presented after the emit step")

endmodule
